### src/ocrrf_pkg.sv
// Shared types, codes and defaults for the component root filter.
`default_nettype none

package ocrrf_pkg;

  localparam int BIG_BOX_DEPTH_DEF     = 64;
  localparam int MIN_LETTER_HEIGHT_DEF = 4;
  localparam int MAX_LETTER_HEIGHT_DEF = 128;

  localparam logic [11:0] DPI_RESET = 12'd300;
  localparam logic [15:0] BIN_MAX   = 16'hFFFF;
  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    KIND_PAGE = 2'd0,
    KIND_BOX  = 2'd1,
    KIND_COMP = 2'd2,
    KIND_BIN  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLASS_NONE       = 2'd0,
    CLASS_DUST       = 2'd1,
    CLASS_DUST_REC   = 2'd2,
    CLASS_LETTER_REC = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_SCAN,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [15:0] top;
    logic signed [15:0] left;
    logic signed [17:0] bottom;
    logic signed [17:0] right;
  } box_t;

endpackage

`default_nettype wire

### src/ocr_component_root_filter.sv
// Root filter for scanned-page components: big-box table, height histogram, classifier.
//
// One transaction at a time. A component (kind 2) is checked against every stored
// big-letter box: the box table has one read port and the containment scan reads
// one box per cycle. A page start sweeps the histogram memory one bin per cycle,
// clearing every bin. After reset the same sweep runs before the first input
// transaction is taken; configuration writes are taken throughout. A finished result
// sits in an output register, so the next transaction is accepted while it waits.
`default_nettype none

module ocr_component_root_filter
  import ocrrf_pkg::*;
#(
  parameter int BIG_BOX_DEPTH     = BIG_BOX_DEPTH_DEF,
  parameter int MIN_LETTER_HEIGHT = MIN_LETTER_HEIGHT_DEF,
  parameter int MAX_LETTER_HEIGHT = MAX_LETTER_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [11:0]        cfg_dpi_vertical_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic signed [15:0] top_i,
  input  logic signed [15:0] left_edge_i,
  input  logic [14:0]        height_i,
  input  logic [14:0]        width_i,
  input  logic [3:0]         scale_i,
  input  logic               is_letter_i,
  input  logic               is_dust_i,
  input  logic               is_punct_i,
  input  logic               is_great_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic [1:0]         root_class_o,
  output logic               inside_big_box_o,
  output logic [15:0]        bin_count_o,
  output logic [23:0]        component_count_o,
  output logic               table_full_o
);

  localparam int BOX_AW  = (BIG_BOX_DEPTH > 1) ? $clog2(BIG_BOX_DEPTH) : 1;
  localparam int BOX_CW  = $clog2(BIG_BOX_DEPTH + 1);
  localparam int HIST_AW = $clog2(MAX_LETTER_HEIGHT);
  localparam logic [BOX_CW-1:0]  BOX_FULL  = BOX_CW'(BIG_BOX_DEPTH);
  localparam logic [HIST_AW-1:0] HIST_LAST = HIST_AW'(MAX_LETTER_HEIGHT - 1);
  localparam logic [14:0]        MIN_H     = 15'(MIN_LETTER_HEIGHT);
  localparam logic [14:0]        MAX_H     = 15'(MAX_LETTER_HEIGHT);

  // storage
  box_t        box_mem [BIG_BOX_DEPTH];
  logic [15:0] hist_mem [MAX_LETTER_HEIGHT];

  state_e state_q, state_d;

  logic [11:0]        dpi_q;
  logic [BOX_CW-1:0]  box_cnt_q, box_cnt_d;
  logic [BOX_CW-1:0]  scan_idx_q, scan_idx_d;
  logic               box_vld_q, box_vld_d;
  logic [HIST_AW-1:0] clr_idx_q, clr_idx_d;
  logic               clr_item_q, clr_item_d;
  logic [23:0]        cnt_q, cnt_d;

  // latched transaction
  kind_e              kind_q;
  logic signed [15:0] top_q, left_q;
  logic signed [17:0] cbot_q, cright_q;
  logic [14:0]        h_q, w_q;
  logic [3:0]         scale_q;
  logic               letter_q, dust_q, punct_q, great_q;

  // working result
  logic        acc_q, acc_d;
  class_e      class_q, class_d;
  logic        inside_q, inside_d;
  logic [15:0] bin_q, bin_d;
  logic        full_q, full_d;
  logic        area_ok_q, area_ok_d;
  logic        aspect_ok_q, aspect_ok_d;
  logic        tall_q, tall_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        out_acc_q;
  logic [1:0]  out_class_q;
  logic        out_inside_q;
  logic [15:0] out_bin_q;
  logic [23:0] out_cnt_q;
  logic        out_full_q;
  logic        out_load;

  // memory ports
  logic               hist_we, hist_re;
  logic [HIST_AW-1:0] hist_waddr;
  logic [15:0]        hist_wdata, hist_rd_q;
  logic               box_we, box_re;
  box_t               box_wdata, box_rd_q;

  logic               accept_in;
  logic               box_full;
  logic               counted;
  logic               hit;
  logic               skip;
  logic [29:0]        area;
  logic [19:0]        w21, h21;
  logic [17:0]        h6;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept_in   = in_valid_i && in_ready_o;
  assign box_full    = (box_cnt_q >= BOX_FULL);

  assign box_wdata.top    = top_i;
  assign box_wdata.left   = left_edge_i;
  assign box_wdata.bottom = $signed({{2{top_i[15]}}, top_i}) + $signed({3'b000, height_i});
  assign box_wdata.right  = $signed({{2{left_edge_i[15]}}, left_edge_i})
                          + $signed({3'b000, width_i});
  assign box_we  = accept_in && (kind_e'(kind_i) == KIND_BOX) && !box_full;
  assign hist_re = accept_in && ((kind_e'(kind_i) == KIND_COMP) ||
                                 (kind_e'(kind_i) == KIND_BIN));

  assign counted = (h_q > MIN_H) && (h_q < MAX_H);
  assign area    = 30'(h_q) * 30'(w_q);
  assign w21     = (20'(w_q) << 4) + (20'(w_q) << 2) + 20'(w_q);
  assign h21     = (20'(h_q) << 4) + (20'(h_q) << 2) + 20'(h_q);
  assign h6      = (18'(h_q) << 2) + (18'(h_q) << 1);

  assign hit = (top_q >= box_rd_q.top) && (left_q >= box_rd_q.left) &&
               (cbot_q <= box_rd_q.bottom) && (cright_q <= box_rd_q.right);

  assign skip = (scale_q > 4'd3) ||
                ((scale_q > 4'd1) && ((scale_q > 4'd2) || tall_q) && !inside_q);

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rd_q <= hist_mem[height_i[HIST_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_we) begin
      box_mem[box_cnt_q[BOX_AW-1:0]] <= box_wdata;
    end
    if (box_re) begin
      box_rd_q <= box_mem[scan_idx_q[BOX_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpi_q <= DPI_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dpi_q <= cfg_dpi_vertical_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      box_cnt_q   <= '0;
      scan_idx_q  <= '0;
      box_vld_q   <= 1'b0;
      clr_idx_q   <= '0;
      clr_item_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      box_cnt_q   <= box_cnt_d;
      scan_idx_q  <= scan_idx_d;
      box_vld_q   <= box_vld_d;
      clr_idx_q   <= clr_idx_d;
      clr_item_q  <= clr_item_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      kind_q   <= kind_e'(kind_i);
      top_q    <= top_i;
      left_q   <= left_edge_i;
      cbot_q   <= box_wdata.bottom;
      cright_q <= box_wdata.right;
      h_q      <= height_i;
      w_q      <= width_i;
      scale_q  <= scale_i;
      letter_q <= is_letter_i;
      dust_q   <= is_dust_i;
      punct_q  <= is_punct_i;
      great_q  <= is_great_i;
    end
    acc_q       <= acc_d;
    class_q     <= class_d;
    inside_q    <= inside_d;
    bin_q       <= bin_d;
    full_q      <= full_d;
    area_ok_q   <= area_ok_d;
    aspect_ok_q <= aspect_ok_d;
    tall_q      <= tall_d;
    if (out_load) begin
      out_acc_q    <= acc_q;
      out_class_q  <= class_q;
      out_inside_q <= inside_q;
      out_bin_q    <= bin_q;
      out_cnt_q    <= cnt_q;
      out_full_q   <= full_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    box_cnt_d   = box_cnt_q;
    scan_idx_d  = scan_idx_q;
    box_vld_d   = 1'b0;
    clr_idx_d   = clr_idx_q;
    clr_item_d  = clr_item_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    acc_d       = acc_q;
    class_d     = class_q;
    inside_d    = inside_q;
    bin_d       = bin_q;
    full_d      = full_q;
    area_ok_d   = area_ok_q;
    aspect_ok_d = aspect_ok_q;
    tall_d      = tall_q;
    hist_we     = 1'b0;
    hist_waddr  = h_q[HIST_AW-1:0];
    hist_wdata  = (hist_rd_q == BIN_MAX) ? hist_rd_q : hist_rd_q + 16'd1;
    box_re      = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_idx_q;
        hist_wdata = '0;
        clr_idx_d  = clr_idx_q + HIST_AW'(1);
        if (clr_idx_q == HIST_LAST) begin
          clr_idx_d  = '0;
          clr_item_d = 1'b0;
          state_d    = clr_item_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept_in) begin
          acc_d    = 1'b0;
          class_d  = CLASS_NONE;
          inside_d = 1'b0;
          bin_d    = '0;
          full_d   = 1'b0;
          unique case (kind_e'(kind_i))
            KIND_PAGE: begin
              box_cnt_d  = '0;
              clr_item_d = 1'b1;
              state_d    = ST_CLEAR;
            end
            KIND_BOX: begin
              full_d = box_full;
              if (!box_full) begin
                box_cnt_d = box_cnt_q + BOX_CW'(1);
              end
              state_d = ST_DONE;
            end
            KIND_COMP, KIND_BIN: begin
              state_d = ST_HIST;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_HIST: begin
        if (kind_q == KIND_BIN) begin
          bin_d   = (h_q < MAX_H) ? hist_rd_q : '0;
          state_d = ST_DONE;
        end else begin
          if (counted) begin
            hist_we = 1'b1;
            if (cnt_q != COUNT_MAX) begin
              cnt_d = cnt_q + 24'd1;
            end
          end
          area_ok_d   = (area >= 30'd6);
          aspect_ok_d = (20'(h_q) < w21) && (20'(w_q) < h21);
          tall_d      = (h6 > (18'(dpi_q) + 18'd1));
          scan_idx_d  = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        box_re    = (scan_idx_q < box_cnt_q);
        box_vld_d = box_re;
        if (box_re) begin
          scan_idx_d = scan_idx_q + BOX_CW'(1);
        end
        if (box_vld_q && hit) begin
          inside_d = 1'b1;
        end
        if (!box_re && !box_vld_q) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!skip && (h_q != '0) && (w_q != '0) && aspect_ok_q && area_ok_q) begin
          acc_d = 1'b1;
          priority if (great_q) begin
            class_d = CLASS_NONE;
          end else if (dust_q && (w_q <= 15'd8) && (h_q == 15'd1)) begin
            class_d = CLASS_NONE;
          end else if (dust_q || punct_q) begin
            class_d = CLASS_DUST;
          end else if (letter_q) begin
            class_d = CLASS_LETTER_REC;
          end else begin
            class_d = CLASS_DUST_REC;
          end
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign root_class_o      = out_class_q;
  assign inside_big_box_o  = out_inside_q;
  assign bin_count_o       = out_bin_q;
  assign component_count_o = out_cnt_q;
  assign table_full_o      = out_full_q;

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> !in_ready_o)
    else $error("input taken again while a transaction is in work");

  a_box_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_cnt_q <= BOX_FULL)
    else $error("big box count beyond table depth");

  a_result_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (!table_full_o && (bin_count_o == '0)))
    else $error("accepted root carries fields of another kind");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the component root filter: directed and random page streams vs. a behavioral model.
`timescale 1ns / 100ps

module tb;
  import ocrrf_pkg::*;

  localparam int BOX_DEPTH = BIG_BOX_DEPTH_DEF;
  localparam int MIN_H     = MIN_LETTER_HEIGHT_DEF;
  localparam int MAX_H     = MAX_LETTER_HEIGHT_DEF;

  localparam logic [3:0] F_NONE   = 4'b0000;
  localparam logic [3:0] F_LETTER = 4'b0001;
  localparam logic [3:0] F_DUST   = 4'b0010;
  localparam logic [3:0] F_PUNCT  = 4'b0100;
  localparam logic [3:0] F_GREAT  = 4'b1000;

  typedef struct {
    kind_e              kind;
    logic signed [15:0] top;
    logic signed [15:0] left;
    logic [14:0]        height;
    logic [14:0]        width;
    logic [3:0]         scale;
    logic               is_letter;
    logic               is_dust;
    logic               is_punct;
    logic               is_great;
  } page_item_t;

  typedef struct {
    logic        accepted;
    class_e      root_class;
    logic        in_box;
    logic [15:0] bin_count;
    logic [23:0] comp_count;
    logic        table_full;
  } root_result_t;

  typedef struct {
    int top;
    int left;
    int h;
    int w;
  } box_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [11:0] cfg_dpi_vertical_i = DPI_RESET;

  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  page_item_t  drv_item = '{kind: KIND_PAGE, default: '0};
  logic [1:0]         kind_i;
  logic signed [15:0] top_i;
  logic signed [15:0] left_edge_i;
  logic [14:0]        height_i;
  logic [14:0]        width_i;
  logic [3:0]         scale_i;
  logic               is_letter_i;
  logic               is_dust_i;
  logic               is_punct_i;
  logic               is_great_i;

  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        accepted_o;
  logic [1:0]  root_class_o;
  logic        inside_big_box_o;
  logic [15:0] bin_count_o;
  logic [23:0] component_count_o;
  logic        table_full_o;

  assign kind_i      = drv_item.kind;
  assign top_i       = drv_item.top;
  assign left_edge_i = drv_item.left;
  assign height_i    = drv_item.height;
  assign width_i     = drv_item.width;
  assign scale_i     = drv_item.scale;
  assign is_letter_i = drv_item.is_letter;
  assign is_dust_i   = drv_item.is_dust;
  assign is_punct_i  = drv_item.is_punct;
  assign is_great_i  = drv_item.is_great;

  ocr_component_root_filter dut (.*);

  // model state
  box_rec_t    box_table [BOX_DEPTH];
  int          box_count = 0;
  logic [15:0] hist [MAX_H] = '{default: '0};
  logic [23:0] comp_count = '0;
  int          dpi = DPI_RESET;

  page_item_t   page_items[$];
  root_result_t root_results_due[$];
  box_rec_t     page_boxes[$];
  int           queued = 0;
  int           err_count = 0;
  int           feed_gap_pct = 15;
  int           drain_stall_pct = 55;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic root_result_t compute_root_result(page_item_t it);
    root_result_t r;
    int t, l, h, w, lim;
    logic hit, skip;
    t = it.top;
    l = it.left;
    h = it.height;
    w = it.width;
    hit = 1'b0;
    skip = 1'b0;
    r = '{accepted: 1'b0, root_class: CLASS_NONE, in_box: 1'b0, bin_count: '0,
          comp_count: '0, table_full: 1'b0};
    case (it.kind)
      KIND_PAGE: begin
        box_count = 0;
        foreach (hist[i]) hist[i] = '0;
      end
      KIND_BOX: begin
        if (box_count >= BOX_DEPTH) begin
          r.table_full = 1'b1;
        end else begin
          box_table[box_count] = '{top: t, left: l, h: h, w: w};
          box_count++;
        end
      end
      KIND_COMP: begin
        lim = (50 * (dpi + 1)) / 300;
        if (h > MIN_H && h < MAX_H) begin
          if (comp_count != COUNT_MAX) comp_count++;
          if (hist[h] != BIN_MAX) hist[h]++;
        end
        for (int i = 0; i < box_count; i++) begin
          if (t >= box_table[i].top && l >= box_table[i].left &&
              t + h <= box_table[i].top + box_table[i].h &&
              l + w <= box_table[i].left + box_table[i].w) hit = 1'b1;
        end
        if (it.scale > 3) skip = 1'b1;
        else if (it.scale > 1 && (it.scale > 2 || h > lim) && !hit) skip = 1'b1;
        r.in_box = hit;
        if (!skip && h != 0 && w != 0 && h / w <= 20 && w / h <= 20 && h * w >= 6) begin
          r.accepted = 1'b1;
          r.root_class = CLASS_DUST_REC;
          if (it.is_letter) r.root_class = CLASS_LETTER_REC;
          if (it.is_dust || it.is_punct) r.root_class = CLASS_DUST;
          if (it.is_dust && ((w + 7) / 8) * h < 2) r.root_class = CLASS_NONE;
          if (it.is_great) r.root_class = CLASS_NONE;
        end
      end
      default: begin
        if (h < MAX_H) r.bin_count = hist[h];
      end
    endcase
    r.comp_count = comp_count;
    return r;
  endfunction

  function automatic page_item_t make_item(kind_e k, int t, int l, int h, int w, int s,
                                           logic [3:0] f);
    page_item_t it;
    it.kind = k;
    it.top = 16'(t);
    it.left = 16'(l);
    it.height = 15'(h);
    it.width = 15'(w);
    it.scale = 4'(s);
    {it.is_great, it.is_punct, it.is_dust, it.is_letter} = f;
    return it;
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 140);
    if (r < 80) return $urandom_range(0, 12);
    return $urandom_range(0, 32767);
  endfunction

  function automatic page_item_t rand_box();
    if ($urandom_range(0, 9) == 0)
      return make_item(KIND_BOX, $urandom, $urandom, $urandom, $urandom, $urandom, 4'($urandom));
    return make_item(KIND_BOX, $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                     $urandom_range(0, 400), $urandom_range(0, 400), $urandom, 4'($urandom));
  endfunction

  function automatic page_item_t rand_comp();
    int t, l, h, w, s;
    box_rec_t b;
    t = $urandom;
    l = $urandom;
    h = rand_len();
    w = rand_len();
    s = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 15);
    if (page_boxes.size() > 0 && $urandom_range(0, 1) == 1) begin
      b = page_boxes[$urandom_range(0, page_boxes.size() - 1)];
      t = b.top + $urandom_range(0, b.h);
      l = b.left + $urandom_range(0, b.w);
      h = $urandom_range(0, b.top + b.h - t);
      w = $urandom_range(0, b.left + b.w - l);
      // nudge some just past the box edge
      case ($urandom_range(0, 7))
        0: h++;
        1: l--;
        default: ;
      endcase
    end
    return make_item(KIND_COMP, t, l, h, w, s, 4'($urandom));
  endfunction

  function automatic page_item_t rand_noise(kind_e k, int h);
    return make_item(k, $urandom, $urandom, h, $urandom, $urandom, 4'($urandom));
  endfunction

  task automatic queue_item(page_item_t it);
    if (it.kind == KIND_PAGE) page_boxes.delete();
    if (it.kind == KIND_BOX && page_boxes.size() < BOX_DEPTH)
      page_boxes.push_back('{top: it.top, left: it.left, h: it.height, w: it.width});
    page_items.push_back(it);
    queued++;
  endtask

  task automatic gen_page();
    int n_box;
    if ($urandom_range(0, 9) != 0) queue_item(rand_noise(KIND_PAGE, $urandom));
    n_box = ($urandom_range(0, 14) == 0) ? $urandom_range(55, 72) : $urandom_range(0, 8);
    repeat (n_box) queue_item(rand_box());
    repeat ($urandom_range(4, 30)) begin
      case ($urandom_range(0, 19))
        0, 1: queue_item(rand_noise(KIND_BIN, ($urandom_range(0, 3) == 0) ?
                                               $urandom : $urandom_range(0, 140)));
        2: queue_item(rand_box());
        3: if ($urandom_range(0, 3) == 0) queue_item(rand_noise(KIND_PAGE, $urandom));
        default: queue_item(rand_comp());
      endcase
    end
  endtask

  task automatic run_random(int n);
    int goal;
    goal = queued + n;
    while (queued < goal) gen_page();
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (page_items.size() != 0 || in_valid_i || root_results_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_dpi(logic [11:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_dpi_vertical_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    dpi = v;
  endtask

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= 50)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) root_results_due.push_back(compute_root_result(drv_item));
      if (!in_valid_i || in_ready_o) begin
        if (page_items.size() > 0 && $urandom_range(0, 99) >= feed_gap_pct) begin
          in_valid_i <= 1'b1;
          drv_item <= page_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    root_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (root_results_due.size() == 0) begin
          err_count++;
          $display("%0t ns: result with none expected, count %0d", $time, component_count_o);
        end else begin
          want = root_results_due.pop_front();
          check_field("accepted", want.accepted, accepted_o);
          check_field("root_class", want.root_class, root_class_o);
          check_field("inside_big_box", want.in_box, inside_big_box_o);
          check_field("bin_count", want.bin_count, bin_count_o);
          check_field("component_count", want.comp_count, component_count_o);
          check_field("table_full", want.table_full, table_full_o);
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= drain_stall_pct);
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_item(make_item(KIND_BIN, 0, 0, 0, 0, 0, F_NONE));
    queue_item(make_item(KIND_PAGE, -1, -1, 32767, 32767, 15, 4'hF));
    queue_item(make_item(KIND_BOX, -32768, -32768, 32767, 32767, 0, F_NONE));
    queue_item(make_item(KIND_BOX, 100, 100, 200, 200, 0, F_NONE));
    queue_item(make_item(KIND_COMP, 150, 150, 60, 30, 2, F_LETTER));
    queue_item(make_item(KIND_COMP, 5000, 5000, 60, 30, 2, F_LETTER));
    queue_item(make_item(KIND_COMP, 5000, 5000, 40, 30, 2, F_NONE));
    queue_item(make_item(KIND_COMP, 150, 150, 20, 20, 3, F_DUST));
    queue_item(make_item(KIND_COMP, 5000, 5000, 20, 20, 3, F_NONE));
    queue_item(make_item(KIND_COMP, 150, 150, 20, 20, 4, F_NONE));
    queue_item(make_item(KIND_COMP, -10, -10, 5, 5, 15, F_PUNCT));
    queue_item(make_item(KIND_COMP, 0, 0, 0, 10, 0, F_NONE));
    queue_item(make_item(KIND_COMP, 0, 0, 10, 0, 0, F_NONE));
    queue_item(make_item(KIND_COMP, 0, 0, 105, 5, 0, F_NONE));
    queue_item(make_item(KIND_COMP, 0, 0, 5, 105, 0, F_NONE));
    queue_item(make_item(KIND_COMP, 0, 0, 2, 2, 0, F_NONE));
    queue_item(make_item(KIND_COMP, 0, 0, 1, 8, 0, F_DUST));
    queue_item(make_item(KIND_COMP, 0, 0, 10, 10, 0, F_GREAT | F_LETTER));
    queue_item(make_item(KIND_COMP, 0, 0, 10, 10, 1, F_PUNCT));
    queue_item(make_item(KIND_COMP, 32767, 32767, 32767, 32767, 0, 4'hF));
    queue_item(make_item(KIND_COMP, 0, 0, 5, 6, 0, F_NONE));
    queue_item(make_item(KIND_COMP, 0, 0, 4, 6, 0, F_NONE));
    queue_item(make_item(KIND_COMP, 0, 0, 127, 10, 0, F_NONE));
    queue_item(make_item(KIND_COMP, 0, 0, 128, 10, 0, F_NONE));
    queue_item(make_item(KIND_BIN, 0, 0, 5, 0, 0, F_NONE));
    queue_item(make_item(KIND_BIN, 0, 0, 127, 0, 0, F_NONE));
    queue_item(make_item(KIND_BIN, 0, 0, 128, 0, 0, F_NONE));
    queue_item(make_item(KIND_BIN, -1, -1, 32767, 32767, 15, 4'hF));

    write_dpi(12'd0);
    run_random(330);
    write_dpi(12'd4095);
    run_random(330);

    feed_gap_pct = 55;
    drain_stall_pct = 15;
    write_dpi(12'd1);
    run_random(330);
    write_dpi(12'd2400);
    run_random(330);

    feed_gap_pct = 0;
    drain_stall_pct = 0;
    write_dpi(12'($urandom_range(2, 2399)));
    run_random(330);
    write_dpi(DPI_RESET);
    run_random(330);

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (err_count == 0 && root_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
src/ocrrf_pkg.sv
src/ocr_component_root_filter.sv
tb/sv/tb.sv
